// ===== design/smpq_pkg.sv =====
// ---------------------------------------------------------------------------
// smpq_pkg
// Shared types and codes for the sorted minimum priority queue: entry
// layout, per-cycle cell control, operation and status codes.
// ---------------------------------------------------------------------------
package smpq_pkg;

   localparam int KEY_W    = 16;
   localparam int TAG_W    = 32;
   localparam int STATUS_W = 2;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_REMOVE = 1'b1
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [KEY_W-1:0] key;
   } entry_type;

   // Broadcast to every cell of the chain in each cycle.
   typedef struct packed {
      logic      ins;
      logic      rem;
      entry_type new_entry;
   } ctl_type;

endpackage

// ===== design/smpq_cell.sv =====
// ---------------------------------------------------------------------------
// smpq_cell
// One slot of the sorted chain. On insert it keeps its entry, takes its
// left neighbor's entry, or takes the new entry; on remove it takes its
// right neighbor's entry.
// ---------------------------------------------------------------------------
module smpq_cell
   import smpq_pkg::*;
(
   input  logic      clock,
   input  ctl_type   ctl,
   input  logic      live,
   input  logic      left_greater,
   input  entry_type left_entry,
   input  entry_type right_entry,
   output entry_type entry,
   output logic      greater
);

   entry_type entry_ff;
   entry_type entry_in;

   // Empty slots rank above any key, so the new entry lands behind equal keys.
   assign greater = !live || (entry_ff.key > ctl.new_entry.key);
   assign entry   = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins && greater) begin
         entry_in = left_greater ? left_entry : ctl.new_entry;
      end else if (ctl.rem) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== design/sorted_min_priority_queue_core.sv =====
// ---------------------------------------------------------------------------
// sorted_min_priority_queue_core
// Bounded priority queue held as a chain of sorted cells, lowest key in
// cell 0. Equal keys leave in arrival order.
//
//   Channel | Dir | tuser               | tdata (lowest bit up)
//   req_    | in  | func                | key, tag
//   rsp_    | out | status              | popped_key, popped_tag, stored_count
//
// A request is taken every cycle the result register is free or drained.
// Its result shows in the cycle after acceptance; all cells update at
// once from one broadcast key compare per cell, so throughput is one
// per cycle unless a stalled result holds req_tready low until it is taken.
// Reset clears the fill count and the result valid; cell contents are
// left as they are and never read past the fill count.
// ---------------------------------------------------------------------------
module sorted_min_priority_queue_core
   import smpq_pkg::*;
#(
   parameter int DEPTH = 8
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [0:0]          req_tuser,  // func
   input  logic [KEY_W+TAG_W-1:0] req_tdata,  // key, tag
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [STATUS_W-1:0] rsp_tuser,  // status
   output logic [((KEY_W+TAG_W+$clog2(DEPTH+1)+7)/8)*8-1:0] rsp_tdata
                                           // popped_key, popped_tag, stored_count
);

   localparam int CountW = $clog2(DEPTH + 1);
   localparam int RspW   = ((KEY_W + TAG_W + CountW + 7) / 8) * 8;
   localparam int PadW   = RspW - (KEY_W + TAG_W + CountW);

   logic [CountW-1:0] count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        status_ff, status_in;
   entry_type         popped_ff, popped_in;
   logic [CountW-1:0] rsp_count_ff;

   ctl_type   ctl;
   logic      accept, is_ins, full, empty;
   logic      live    [DEPTH];
   logic      greater [DEPTH];
   entry_type entries [DEPTH];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_ins     = (func_type'(req_tuser[0]) == FUNC_INSERT);
   assign full       = (count_ff == CountW'(DEPTH));
   assign empty      = (count_ff == '0);

   always_comb begin
      ctl.ins           = accept && is_ins && !full;
      ctl.rem           = accept && !is_ins && !empty;
      ctl.new_entry.key = req_tdata[KEY_W-1:0];
      ctl.new_entry.tag = req_tdata[KEY_W+TAG_W-1:KEY_W];
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      logic      left_greater;

      assign live[i] = (count_ff > CountW'(i));

      if (i == 0) begin : g_first
         assign left_entry   = '0;
         assign left_greater = 1'b0;
      end else begin : g_mid
         assign left_entry   = entries[i-1];
         assign left_greater = greater[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_inner
         assign right_entry = entries[i+1];
      end

      smpq_cell u_cell (
         .clock        (clock),
         .ctl          (ctl),
         .live         (live[i]),
         .left_greater (left_greater),
         .left_entry   (left_entry),
         .right_entry  (right_entry),
         .entry        (entries[i]),
         .greater      (greater[i])
      );
   end

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = status_ff;
      popped_in    = popped_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         popped_in    = '0;
         status_in    = STATUS_OK;
         if (is_ins) begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               count_in = count_ff + CountW'(1);
            end
         end else begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               popped_in = entries[0];
               count_in  = count_ff - CountW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         popped_ff    <= popped_in;
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {{PadW{1'b0}}, rsp_count_ff, popped_ff.tag, popped_ff.key};

   // Fill count stays within the chain.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(DEPTH))
      else $error("fill count exceeds depth");

   // Result register comes out of reset empty.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A successful insert grows the count by one.
   a_ins_count: assert property (@(posedge clock) disable iff (reset)
      ctl.ins |=> count_ff == $past(count_ff) + CountW'(1))
      else $error("insert did not advance fill count");

   // Live cells stay sorted by ascending key.
   for (genvar j = 0; j < DEPTH - 1; j++) begin : g_sorted
      a_sorted: assert property (@(posedge clock) disable iff (reset)
         live[j+1] |-> entries[j].key <= entries[j+1].key)
         else $error("chain out of order");
   end

endmodule

// ===== tb/tb_sorted_min_priority_queue_core.sv =====
// ---------------------------------------------------------------------------
// tb_sorted_min_priority_queue_core
// Self-checking bench for the sorted minimum priority queue. A directed
// table covers empty and full queues, key and tag extremes and equal-key
// ordering. Random insert/remove traffic follows, with the insert mix
// swinging between drain-heavy and fill-heavy spans. Every response is
// compared field by field against a behavioral copy of the queue (typed
// directed rows: against the table's own result). Both sides idle in random
// bursts. The receiver holds off for long stretches to back up the request
// side. The sender pauses once until the queue of expected responses is empty.
// ---------------------------------------------------------------------------
module tb_sorted_min_priority_queue_core;
   import smpq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH      = 8;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int RSP_W      = ((KEY_W + TAG_W + CNT_W + 7) / 8) * 8;
   localparam int N_DIRECTED = 24;
   localparam int N_RANDOM   = 1600;
   localparam int N_TOTAL    = N_DIRECTED + N_RANDOM;
   localparam int QUIET      = 200;
   localparam int PAUSE_AT   = 700;
   localparam int MAX_REPORT = 10;

   typedef struct packed {
      status_type       status;
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
      logic [CNT_W-1:0] count;
   } queue_result_type;

   typedef struct packed {
      func_type         func;
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
      logic             typed;
      queue_result_type result;
   } directed_row_type;

   localparam queue_result_type UNTYPED = '{STATUS_OK, '0, '0, '0};

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [0:0]             req_tuser  = '0;  // func
   logic [KEY_W+TAG_W-1:0] req_tdata  = '0;  // key, tag
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [STATUS_W-1:0]    rsp_tuser;        // status
   logic [RSP_W-1:0]       rsp_tdata;        // popped_key, popped_tag, stored_count

   // Behavioral copy of the queue
   logic [KEY_W-1:0] held_key [DEPTH];
   logic [TAG_W-1:0] held_tag [DEPTH];
   int               held_count;

   queue_result_type expected_results [$];
   int               items_sent;
   int               results_checked;
   int               error_count;

   directed_row_type directed_rows [N_DIRECTED] = '{
      '{FUNC_REMOVE, 16'h0000, 32'h0000_0000, 1'b1, '{STATUS_EMPTY, 16'h0, 32'h0, 4'd0}},
      '{FUNC_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, '{STATUS_OK, 16'h0, 32'h0, 4'd1}},
      '{FUNC_INSERT, 16'h0000, 32'h0000_0000, 1'b1, '{STATUS_OK, 16'h0, 32'h0, 4'd2}},
      '{FUNC_REMOVE, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, '{STATUS_OK, 16'h0, 32'h0, 4'd1}},
      '{FUNC_INSERT, 16'h8000, 32'hA5A5_A5A5, 1'b0, UNTYPED},
      '{FUNC_INSERT, 16'h8000, 32'h5A5A_5A5A, 1'b0, UNTYPED},
      '{FUNC_INSERT, 16'h8000, 32'h0000_0001, 1'b0, UNTYPED},
      '{FUNC_INSERT, 16'h0001, 32'h8000_0000, 1'b0, UNTYPED},
      '{FUNC_INSERT, 16'hFFFF, 32'h0000_0002, 1'b0, UNTYPED},
      '{FUNC_INSERT, 16'h7FFF, 32'h7FFF_FFFF, 1'b0, UNTYPED},
      '{FUNC_INSERT, 16'h0000, 32'hFFFF_FFFF, 1'b0, UNTYPED},
      '{FUNC_INSERT, 16'h1234, 32'h0000_0003, 1'b1, '{STATUS_FULL, 16'h0, 32'h0, 4'd8}},
      '{FUNC_INSERT, 16'h0000, 32'hFFFF_FFFF, 1'b1, '{STATUS_FULL, 16'h0, 32'h0, 4'd8}},
      '{FUNC_REMOVE, 16'h0000, 32'h0000_0000, 1'b0, UNTYPED},
      '{FUNC_INSERT, 16'h8000, 32'h0000_0004, 1'b0, UNTYPED},
      '{FUNC_REMOVE, 16'h5555, 32'h5555_5555, 1'b0, UNTYPED},
      '{FUNC_REMOVE, 16'hAAAA, 32'hAAAA_AAAA, 1'b0, UNTYPED},
      '{FUNC_REMOVE, 16'h0000, 32'h0000_0000, 1'b0, UNTYPED},
      '{FUNC_REMOVE, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, UNTYPED},
      '{FUNC_REMOVE, 16'h0000, 32'h0000_0000, 1'b0, UNTYPED},
      '{FUNC_REMOVE, 16'h0000, 32'h0000_0000, 1'b0, UNTYPED},
      '{FUNC_REMOVE, 16'h0000, 32'h0000_0000, 1'b0, UNTYPED},
      '{FUNC_REMOVE, 16'h0000, 32'h0000_0000, 1'b0, UNTYPED},
      '{FUNC_REMOVE, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, '{STATUS_EMPTY, 16'h0, 32'h0, 4'd0}}
   };

   sorted_min_priority_queue_core #(
      .DEPTH(DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("sorted_min_priority_queue_core regression: fail");
      $finish;
   end

   // Apply one request to the behavioral queue and return its response.
   function automatic queue_result_type apply_queue_op(input func_type f,
                                                       input logic [KEY_W-1:0] k,
                                                       input logic [TAG_W-1:0] t);
      queue_result_type r;
      int               pos;
      int               i;
      r        = '0;
      r.status = STATUS_OK;
      if (f == FUNC_INSERT) begin
         if (held_count >= DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            pos = 0;
            // equal keys go behind the stored ones
            while (pos < held_count && held_key[pos] <= k) pos++;
            for (i = held_count; i > pos; i--) begin
               held_key[i] = held_key[i-1];
               held_tag[i] = held_tag[i-1];
            end
            held_key[pos] = k;
            held_tag[pos] = t;
            held_count++;
         end
      end else if (held_count == 0) begin
         r.status = STATUS_EMPTY;
      end else begin
         r.key = held_key[0];
         r.tag = held_tag[0];
         for (i = 1; i < held_count; i++) begin
            held_key[i-1] = held_key[i];
            held_tag[i-1] = held_tag[i];
         end
         held_count--;
      end
      r.count = held_count[CNT_W-1:0];
      return r;
   endfunction

   task automatic send_request(input func_type f, input logic [KEY_W-1:0] k,
                               input logic [TAG_W-1:0] t, input logic typed,
                               input queue_result_type typed_result);
      queue_result_type predicted;
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {t, k};
      do @(posedge clock); while (!req_tready);
      predicted = apply_queue_op(f, k, t);
      expected_results.push_back(typed ? typed_result : predicted);
      items_sent++;
   endtask

   // Response side: check each response, drive tready with idle bursts
   initial begin
      queue_result_type want;
      queue_result_type got;
      int               stall_left;
      int               idle_level;
      int               cycle_n;
      bit               long_hold_a;
      bit               long_hold_b;
      stall_left  = 0;
      idle_level  = 0;
      cycle_n     = 0;
      long_hold_a = 1'b0;
      long_hold_b = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.status = status_type'(rsp_tuser);
            got.key    = rsp_tdata[KEY_W-1:0];
            got.tag    = rsp_tdata[KEY_W+TAG_W-1:KEY_W];
            got.count  = rsp_tdata[KEY_W+TAG_W+CNT_W-1:KEY_W+TAG_W];
            if (expected_results.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORT)
                  $display("[%0t] unexpected response: status=%0d key=%h tag=%h count=%0d",
                           $realtime, got.status, got.key, got.tag, got.count);
            end else begin
               want = expected_results.pop_front();
               results_checked++;
               if (got.status !== want.status || got.key !== want.key ||
                   got.tag !== want.tag || got.count !== want.count) begin
                  error_count++;
                  if (error_count <= MAX_REPORT)
                     $display("[%0t] rsp %0d exp %0d/%h/%h/%0d got %0d/%h/%h/%0d",
                              $realtime, results_checked, want.status, want.key,
                              want.tag, want.count, got.status, got.key, got.tag,
                              got.count);
               end
            end
         end

         cycle_n++;
         if (cycle_n % 128 == 0) idle_level = $urandom_range(0, 2);

         // long hold-offs back the queue up into the request side
         if (!long_hold_a && results_checked >= 250) begin
            long_hold_a = 1'b1;
            stall_left  = 150;
         end else if (!long_hold_b && results_checked >= 900) begin
            long_hold_b = 1'b1;
            stall_left  = 150;
         end

         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (results_checked < N_TOTAL - QUIET && idle_level != 0 &&
                      $urandom_range(0, (idle_level == 1) ? 11 : 2) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Request side: directed table, then random traffic
   initial begin
      func_type         f;
      logic [KEY_W-1:0] k;
      logic [TAG_W-1:0] t;
      int               insert_pct;
      int               gap_level;
      int               n;
      held_count      = 0;
      items_sent      = 0;
      results_checked = 0;
      error_count     = 0;
      insert_pct      = 50;
      gap_level       = 0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].func, directed_rows[i].key, directed_rows[i].tag,
                      directed_rows[i].typed, directed_rows[i].result);
      end

      for (n = 0; n < N_RANDOM; n++) begin
         // swing between drain-heavy and fill-heavy spans
         if (n % 40 == 0) begin
            case ($urandom_range(0, 4))
               0:       insert_pct = 10;
               1:       insert_pct = 25;
               2:       insert_pct = 50;
               3:       insert_pct = 75;
               default: insert_pct = 90;
            endcase
         end
         if (n % 64 == 0) gap_level = $urandom_range(0, 2);

         if (n == PAUSE_AT) begin
            // hold until every outstanding response has come back
            req_tvalid <= 1'b0;
            wait (results_checked == items_sent);
            @(posedge clock);
         end

         f = ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_REMOVE;
         case ($urandom_range(0, 9))
            0, 1, 2: k = KEY_W'($urandom_range(0, 7));
            3: begin
               case ($urandom_range(0, 3))
                  0:       k = 16'h0000;
                  1:       k = 16'hFFFF;
                  2:       k = 16'h7FFF;
                  default: k = 16'h8000;
               endcase
            end
            default: k = KEY_W'($urandom_range(0, 65535));
         endcase
         t = $urandom;
         send_request(f, k, t, 1'b0, UNTYPED);

         if (n < N_RANDOM - QUIET && gap_level != 0 &&
             $urandom_range(0, (gap_level == 1) ? 11 : 2) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
      end

      req_tvalid <= 1'b0;
      wait (results_checked == items_sent);
      repeat (8) @(posedge clock);

      if (error_count == 0 && expected_results.size() == 0) begin
         $display("sorted_min_priority_queue_core regression: pass");
      end else begin
         $display("sorted_min_priority_queue_core regression: fail");
      end
      $finish;
   end

endmodule

// ===== sorted_min_priority_queue_core.f =====
design/smpq_pkg.sv
design/smpq_cell.sv
design/sorted_min_priority_queue_core.sv
tb/tb_sorted_min_priority_queue_core.sv
